@@ rtl/ttb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants of the triangle tile binner: request and result
// items, configuration view, setup record passed from the front to the back.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int EW  = 40;  // edge function width
    localparam int DW  = 17;  // edge delta width
    localparam int CW  = 3;   // tile coordinate width
    localparam int TNW = 6;   // tile number width
    localparam int FNW = 10;  // face number width
    localparam int NE  = 3;   // edges per triangle

    localparam logic [1:0] REG_WINDING_CULL = 2'd0;
    localparam logic [1:0] REG_TILES_ACROSS = 2'd1;
    localparam logic [1:0] REG_TILES_DOWN   = 2'd2;

    localparam logic [1:0] CULL_CW  = 2'd1;
    localparam logic [1:0] CULL_CCW = 2'd2;

    localparam logic CMD_BIN       = 1'b0;
    localparam logic CMD_NEW_BATCH = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] v0_x;
        logic signed [15:0] v0_y;
        logic signed [15:0] v1_x;
        logic signed [15:0] v1_y;
        logic signed [15:0] v2_x;
        logic signed [15:0] v2_y;
    } triangle_t;

    typedef struct packed {
        logic [TNW-1:0] tile_number;
        logic [FNW-1:0] face_number;
        logic           fully_covered;
        logic           first_in_tile;
        logic           last;
    } tile_t;

    // tile counts already saturated into range
    typedef struct packed {
        logic [1:0] winding_cull;
        logic [3:0] tiles_across;
        logic [3:0] tiles_down;
    } cfg_t;

    typedef struct packed {
        logic                   cmd;
        logic [FNW-1:0]         face;
        logic [CW-1:0]          tx0;
        logic [CW-1:0]          tx1;
        logic [CW-1:0]          ty0;
        logic [CW-1:0]          ty1;
        logic                   no_test;
        logic [NE-1:0][EW-1:0]  r0;
        logic [NE-1:0][DW-1:0]  dx;
        logic [NE-1:0][DW-1:0]  dy;
    } setup_t;

endpackage

@@ rtl/ttb_fifo.sv @@
// ----------------------------------------------------------------------------
// ttb_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ttb_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t data_in,
    input  logic  pop,
    output logic  empty,
    output item_t data_out
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    item_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CNW-1:0] count_reg;
    logic           do_push;
    logic           do_pop;

    assign full     = (count_reg == CNW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

@@ rtl/ttb_front.sv @@
// ----------------------------------------------------------------------------
// ttb_front
// Triangle setup: area and culling, winding fix, face numbering, clamped tile
// box and edge values at the box origin, through one shared multiplier.
// ----------------------------------------------------------------------------
module ttb_front #(
    parameter int TILE_SHIFT = 5,
    parameter int MAX_FACES  = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ttb_pkg::triangle_t triangle,
    input  ttb_pkg::cfg_t      cfg,
    output logic               q_push,
    input  logic               q_full,
    output ttb_pkg::setup_t    q_item
);

    import ttb_pkg::*;

    localparam int SH  = TILE_SHIFT + 4;
    localparam int FCW = $clog2(MAX_FACES);
    localparam int PW  = 2 * DW + 1;

    typedef enum logic [2:0] {
        F_IDLE,
        F_AREA_A,
        F_AREA_B,
        F_SETUP,
        F_EDGE,
        F_PUSH
    } fstate_t;

    fstate_t                state_reg;
    logic                   cmd_reg;
    logic signed [15:0]     x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [PW-1:0]   prod_reg;
    logic [FCW-1:0]         count_reg;
    logic [FNW-1:0]         face_reg;
    logic signed [DW-1:0]   dx_reg [NE];
    logic signed [DW-1:0]   dy_reg [NE];
    logic [NE-1:0]          bias_reg;
    logic [CW-1:0]          tx0_reg, tx1_reg, ty0_reg, ty1_reg;
    logic                   no_test_reg;
    logic [2:0]             step_reg;
    logic signed [EW-1:0]   acc_reg;
    logic signed [EW-1:0]   r0_reg [NE];

    logic [1:0]             eidx;
    logic signed [15:0]     vx, vy;
    logic signed [DW:0]     xa0, ya0;
    logic signed [DW-1:0]   mop_a;
    logic signed [DW:0]     mop_b;
    logic signed [PW-1:0]   mul_p;
    logic signed [PW:0]     area;
    logic                   culled;
    logic signed [DW-1:0]   dxv [NE];
    logic signed [DW-1:0]   dyv [NE];
    logic signed [15:0]     mnx, mxx, mny, mxy;
    logic signed [15:0]     tmnx, tmxx, tmny, tmxy;
    logic signed [15:0]     ta_m1, td_m1;
    logic signed [15:0]     tx0c, tx1c, ty0c, ty1c;
    logic                   box_empty;
    logic                   no_test;

    function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

    assign full = (state_reg != F_IDLE);

    // edge origin vertex and box origin
    assign eidx = step_reg[2:1];
    always_comb
    begin
        case (eidx)
            2'd1:    begin vx = x1_reg; vy = y1_reg; end
            2'd2:    begin vx = x2_reg; vy = y2_reg; end
            default: begin vx = x0_reg; vy = y0_reg; end
        endcase
    end
    assign xa0 = $signed((DW + 1)'(tx0_reg) << SH);
    assign ya0 = $signed((DW + 1)'(ty0_reg) << SH);

    // shared multiplier
    always_comb
    begin
        unique case (state_reg)
            F_AREA_A:
            begin
                mop_a = DW'(x2_reg) - DW'(x0_reg);
                mop_b = (DW + 1)'(y2_reg) - (DW + 1)'(y1_reg);
            end
            F_AREA_B:
            begin
                mop_a = DW'(y2_reg) - DW'(y0_reg);
                mop_b = (DW + 1)'(x2_reg) - (DW + 1)'(x1_reg);
            end
            F_EDGE:
            begin
                if (step_reg[0])
                begin
                    mop_a = dx_reg[eidx];
                    mop_b = (DW + 1)'(vy) - ya0;
                end
                else
                begin
                    mop_a = dy_reg[eidx];
                    mop_b = (DW + 1)'(vx) - xa0;
                end
            end
            default:
            begin
                mop_a = '0;
                mop_b = '0;
            end
        endcase
    end
    assign mul_p = mop_a * mop_b;

    assign area   = (PW + 1)'(prod_reg) - (PW + 1)'(mul_p);
    assign culled = ((cfg.winding_cull == CULL_CCW) && (area > 0))
                 || ((cfg.winding_cull == CULL_CW) && (area < 0));

    // edge deltas and tile box
    always_comb
    begin
        dxv[0] = DW'(x0_reg) - DW'(x1_reg);
        dxv[1] = DW'(x1_reg) - DW'(x2_reg);
        dxv[2] = DW'(x2_reg) - DW'(x0_reg);
        dyv[0] = DW'(y0_reg) - DW'(y1_reg);
        dyv[1] = DW'(y1_reg) - DW'(y2_reg);
        dyv[2] = DW'(y2_reg) - DW'(y0_reg);
    end

    assign mnx  = min3(x0_reg, x1_reg, x2_reg);
    assign mxx  = max3(x0_reg, x1_reg, x2_reg);
    assign mny  = min3(y0_reg, y1_reg, y2_reg);
    assign mxy  = max3(y0_reg, y1_reg, y2_reg);
    assign tmnx = mnx >>> SH;
    assign tmxx = mxx >>> SH;
    assign tmny = mny >>> SH;
    assign tmxy = mxy >>> SH;
    assign ta_m1 = $signed(16'(cfg.tiles_across)) - 16'sd1;
    assign td_m1 = $signed(16'(cfg.tiles_down)) - 16'sd1;
    assign tx0c = (tmnx < 16'sd0) ? 16'sd0 : tmnx;
    assign tx1c = (tmxx > ta_m1) ? ta_m1 : tmxx;
    assign ty0c = (tmny < 16'sd0) ? 16'sd0 : tmny;
    assign ty1c = (tmxy > td_m1) ? td_m1 : tmxy;
    assign box_empty = (tx0c > tx1c) || (ty0c > ty1c);
    assign no_test   = ((tx1c - tx0c) <= 16'sd2) || ((ty1c - ty0c) <= 16'sd2);

    assign q_push = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        q_item.cmd     = cmd_reg;
        q_item.face    = face_reg;
        q_item.tx0     = tx0_reg;
        q_item.tx1     = tx1_reg;
        q_item.ty0     = ty0_reg;
        q_item.ty1     = ty1_reg;
        q_item.no_test = no_test_reg;
        for (int e = 0; e < NE; e++)
        begin
            q_item.r0[e] = r0_reg[e];
            q_item.dx[e] = dx_reg[e];
            q_item.dy[e] = dy_reg[e];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            count_reg <= '0;
            cmd_reg   <= CMD_BIN;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        cmd_reg <= triangle.cmd;
                        if (triangle.cmd == CMD_NEW_BATCH)
                        begin
                            count_reg <= '0;
                            state_reg <= F_PUSH;
                        end
                        else
                        begin
                            x0_reg    <= triangle.v0_x;
                            y0_reg    <= triangle.v0_y;
                            x1_reg    <= triangle.v1_x;
                            y1_reg    <= triangle.v1_y;
                            x2_reg    <= triangle.v2_x;
                            y2_reg    <= triangle.v2_y;
                            state_reg <= F_AREA_A;
                        end
                    end
                end
                F_AREA_A:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= F_AREA_B;
                end
                F_AREA_B:
                begin
                    if (culled)
                    begin
                        state_reg <= F_IDLE;
                    end
                    else
                    begin
                        // counterclockwise gets v1 and v2 swapped
                        if (area > 0)
                        begin
                            x1_reg <= x2_reg;
                            y1_reg <= y2_reg;
                            x2_reg <= x1_reg;
                            y2_reg <= y1_reg;
                        end
                        face_reg  <= FNW'(count_reg);
                        count_reg <= (count_reg == FCW'(MAX_FACES - 1)) ? '0
                                                                        : count_reg + 1'b1;
                        state_reg <= F_SETUP;
                    end
                end
                F_SETUP:
                begin
                    for (int e = 0; e < NE; e++)
                    begin
                        dx_reg[e]   <= dxv[e];
                        dy_reg[e]   <= dyv[e];
                        bias_reg[e] <= (dyv[e] < 0) || ((dyv[e] == 0) && (dxv[e] > 0));
                    end
                    tx0_reg     <= CW'(tx0c);
                    tx1_reg     <= CW'(tx1c);
                    ty0_reg     <= CW'(ty0c);
                    ty1_reg     <= CW'(ty1c);
                    no_test_reg <= no_test;
                    step_reg    <= '0;
                    state_reg   <= box_empty ? F_IDLE : F_EDGE;
                end
                F_EDGE:
                begin
                    if (step_reg[0])
                    begin
                        r0_reg[eidx] <= acc_reg - EW'(mul_p);
                    end
                    else
                    begin
                        acc_reg <= EW'(mul_p) + EW'(bias_reg[eidx]);
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd5)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/ttb_back.sv @@
// ----------------------------------------------------------------------------
// ttb_back
// Tile walk: steps the edge values across the clamped box one tile per cycle
// while the output does not stall, runs the corner test, tracks first touches
// and holds one result back so the final one of a triangle carries the last
// flag.
module ttb_back #(
    parameter int TILE_SHIFT = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    output logic            q_pop,
    input  ttb_pkg::setup_t q_item,
    input  ttb_pkg::cfg_t   cfg,
    output logic            o_push,
    input  logic            o_full,
    output ttb_pkg::tile_t  o_item
);

    import ttb_pkg::*;

    localparam int SH = TILE_SHIFT + 4;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WALK,
        B_DONE
    } bstate_t;

    bstate_t                state_reg;
    logic [FNW-1:0]         face_reg;
    logic [CW-1:0]          tx0_reg, tx1_reg, ty1_reg;
    logic [CW-1:0]          x_reg, y_reg;
    logic [TNW-1:0]         base_reg;
    logic                   no_test_reg;
    logic signed [EW-1:0]   v_reg   [NE];
    logic signed [EW-1:0]   r_reg   [NE];
    logic signed [EW-1:0]   dxs_reg [NE];
    logic signed [EW-1:0]   dys_reg [NE];
    logic signed [EW-1:0]   dxm_reg [NE];
    logic signed [EW-1:0]   dym_reg [NE];
    logic signed [EW-1:0]   dd_reg  [NE];
    logic [2**TNW-1:0]      touched_reg;
    logic                   pend_valid_reg;
    tile_t                  pend_reg;

    logic signed [EW-1:0]   ld_dxs [NE];
    logic signed [EW-1:0]   ld_dys [NE];
    logic signed [EW-1:0]   ld_dxm [NE];
    logic signed [EW-1:0]   ld_dym [NE];
    logic [3:0]             mask [NE];
    logic                   any_out;
    logic                   all_in;
    logic                   emit;
    logic                   at_end;
    logic                   stall;
    logic [TNW-1:0]         tile_sel;
    tile_t                  new_item;

    // step terms: one tile span and span minus one pixel step
    always_comb
    begin
        for (int e = 0; e < NE; e++)
        begin
            ld_dxs[e] = EW'($signed(q_item.dx[e])) <<< SH;
            ld_dys[e] = EW'($signed(q_item.dy[e])) <<< SH;
            ld_dxm[e] = ld_dxs[e] - EW'($signed(q_item.dx[e]));
            ld_dym[e] = ld_dys[e] - EW'($signed(q_item.dy[e]));
        end
    end

    // four-corner test
    always_comb
    begin
        any_out = 1'b0;
        all_in  = 1'b1;
        for (int e = 0; e < NE; e++)
        begin
            mask[e][0] = (v_reg[e] > 0);
            mask[e][1] = ((v_reg[e] - dym_reg[e]) > 0);
            mask[e][2] = ((v_reg[e] + dxm_reg[e]) > 0);
            mask[e][3] = ((v_reg[e] + dd_reg[e]) > 0);
            any_out = any_out || (mask[e] == 4'h0);
            all_in  = all_in && (mask[e] == 4'hF);
        end
    end

    assign emit     = no_test_reg || !any_out;
    assign tile_sel = base_reg + TNW'(x_reg);
    assign at_end   = (x_reg == tx1_reg) && (y_reg == ty1_reg);
    assign stall    = emit && pend_valid_reg && o_full;

    always_comb
    begin
        new_item.tile_number   = tile_sel;
        new_item.face_number   = face_reg;
        new_item.fully_covered = !no_test_reg && all_in;
        new_item.first_in_tile = !touched_reg[tile_sel];
        new_item.last          = 1'b0;
    end

    assign q_pop  = (state_reg == B_IDLE) && !q_empty;
    assign o_push = pend_valid_reg && !o_full
                 && (((state_reg == B_WALK) && emit) || (state_reg == B_DONE));

    always_comb
    begin
        o_item      = pend_reg;
        o_item.last = (state_reg == B_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            touched_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (q_item.cmd == CMD_NEW_BATCH)
                        begin
                            touched_reg <= '0;
                        end
                        else
                        begin
                            face_reg    <= q_item.face;
                            tx0_reg     <= q_item.tx0;
                            tx1_reg     <= q_item.tx1;
                            ty1_reg     <= q_item.ty1;
                            x_reg       <= q_item.tx0;
                            y_reg       <= q_item.ty0;
                            base_reg    <= TNW'(q_item.ty0) * TNW'(cfg.tiles_across);
                            no_test_reg <= q_item.no_test;
                            for (int e = 0; e < NE; e++)
                            begin
                                v_reg[e]   <= $signed(q_item.r0[e]);
                                r_reg[e]   <= $signed(q_item.r0[e]);
                                dxs_reg[e] <= ld_dxs[e];
                                dys_reg[e] <= ld_dys[e];
                                dxm_reg[e] <= ld_dxm[e];
                                dym_reg[e] <= ld_dym[e];
                                dd_reg[e]  <= ld_dxm[e] - ld_dym[e];
                            end
                            state_reg <= B_WALK;
                        end
                    end
                end
                B_WALK:
                begin
                    if (!stall)
                    begin
                        if (emit)
                        begin
                            pend_reg              <= new_item;
                            pend_valid_reg        <= 1'b1;
                            touched_reg[tile_sel] <= 1'b1;
                        end
                        if (at_end)
                        begin
                            state_reg <= B_DONE;
                        end
                        else if (x_reg == tx1_reg)
                        begin
                            x_reg    <= tx0_reg;
                            y_reg    <= y_reg + 1'b1;
                            base_reg <= base_reg + TNW'(cfg.tiles_across);
                            for (int e = 0; e < NE; e++)
                            begin
                                r_reg[e] <= r_reg[e] + dxs_reg[e];
                                v_reg[e] <= r_reg[e] + dxs_reg[e];
                            end
                        end
                        else
                        begin
                            x_reg <= x_reg + 1'b1;
                            for (int e = 0; e < NE; e++)
                            begin
                                v_reg[e] <= v_reg[e] - dys_reg[e];
                            end
                        end
                    end
                end
                B_DONE:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= B_IDLE;
                    end
                    else if (!o_full)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_walk_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_WALK |-> x_reg >= tx0_reg && x_reg <= tx1_reg && y_reg <= ty1_reg)
        else $error("tile walk left the box");

    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_item.cmd == CMD_NEW_BATCH |=> touched_reg == '0)
        else $error("new batch did not clear tile marks");

    a_done_drains: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DONE && !o_full |=> state_reg == B_IDLE && !pend_valid_reg)
        else $error("held result not flushed at end of triangle");

endmodule

@@ rtl/triangle_tile_binner_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_tile_binner_unit
// Bins screen triangles into tiles: culling, setup and a tile walk with a
// four-corner test, joined by a short setup queue and a result queue.
// ----------------------------------------------------------------------------
// a binned triangle holds the input through area, setup, edge and push states,
// a culled one through area states, an off-screen one through area and setup
// states, a new-batch request through the push state, longer while the setup
// queue is full; the walk spends one cycle per tile of the clamped box plus
// output stalls; a triangle's final result leaves once the result queue has room
// rst_n clears face counter, tile marks and queues at once and loads defaults
module triangle_tile_binner_unit #(
    parameter int TILE_SHIFT       = 5,
    parameter int MAX_TILES_ACROSS = 8,
    parameter int MAX_TILES_DOWN   = 8,
    parameter int MAX_FACES        = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [3:0]         wr_data,
    input  logic               push,
    output logic               full,
    input  ttb_pkg::triangle_t triangle,
    output logic               empty,
    input  logic               pop,
    output ttb_pkg::tile_t     tile
);

    import ttb_pkg::*;

    logic [1:0] winding_cull_reg;
    logic [3:0] tiles_across_reg;
    logic [3:0] tiles_down_reg;
    cfg_t       cfg;
    logic       front_busy;
    logic       sq_push, sq_full, sq_pop, sq_empty;
    setup_t     sq_in, sq_out;
    logic       rq_push, rq_full;
    tile_t      rq_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            winding_cull_reg <= 2'd0;
            tiles_across_reg <= 4'd8;
            tiles_down_reg   <= 4'd8;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WINDING_CULL: winding_cull_reg <= wr_data[1:0];
                REG_TILES_ACROSS: tiles_across_reg <= wr_data;
                REG_TILES_DOWN:   tiles_down_reg   <= wr_data;
                default:          ;
            endcase
        end
    end

    // tile counts saturate into 1..max
    always_comb
    begin
        cfg.winding_cull = winding_cull_reg;
        if (tiles_across_reg == 4'd0)
            cfg.tiles_across = 4'd1;
        else if (tiles_across_reg > 4'(MAX_TILES_ACROSS))
            cfg.tiles_across = 4'(MAX_TILES_ACROSS);
        else
            cfg.tiles_across = tiles_across_reg;
        if (tiles_down_reg == 4'd0)
            cfg.tiles_down = 4'd1;
        else if (tiles_down_reg > 4'(MAX_TILES_DOWN))
            cfg.tiles_down = 4'(MAX_TILES_DOWN);
        else
            cfg.tiles_down = tiles_down_reg;
    end

    assign full = front_busy;

    ttb_front #(
        .TILE_SHIFT (TILE_SHIFT),
        .MAX_FACES  (MAX_FACES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (front_busy),
        .triangle (triangle),
        .cfg      (cfg),
        .q_push   (sq_push),
        .q_full   (sq_full),
        .q_item   (sq_in)
    );

    ttb_fifo #(
        .item_t (setup_t),
        .DEPTH  (2)
    ) u_setup_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (sq_push),
        .full     (sq_full),
        .data_in  (sq_in),
        .pop      (sq_pop),
        .empty    (sq_empty),
        .data_out (sq_out)
    );

    ttb_back #(
        .TILE_SHIFT (TILE_SHIFT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (sq_empty),
        .q_pop   (sq_pop),
        .q_item  (sq_out),
        .cfg     (cfg),
        .o_push  (rq_push),
        .o_full  (rq_full),
        .o_item  (rq_in)
    );

    ttb_fifo #(
        .item_t (tile_t),
        .DEPTH  (2)
    ) u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rq_push),
        .full     (rq_full),
        .data_in  (rq_in),
        .pop      (pop),
        .empty    (empty),
        .data_out (tile)
    );

endmodule
